>>> design/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame layout: start byte, 22 data bytes, flag byte, end byte.
    localparam int WIN_LEN    = 25;
    localparam int DATA_BYTES = 22;
    localparam int NUM_CH     = 16;
    localparam int CH_W       = 11;
    localparam int IDX_W      = 4;
    localparam int FILL_W     = 5;
    localparam int DATA_W     = 8 * DATA_BYTES;

    localparam logic [7:0] SYNC_HEAD = 8'h0F;
    localparam logic [7:0] SYNC_TAIL = 8'h00;

    // Bit positions within the flag byte.
    localparam int FLAG_LOST_BIT = 2;
    localparam int FLAG_FS_BIT   = 3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd200000;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_FRAME
    } sfd_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } sfd_cmd_t;

    typedef struct packed {
        logic frame_hit;
        logic chan_last;
    } sfd_status_t;

endpackage

>>> design/sfd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_regs
// APB register file holding the data-valid timeout.
// ----------------------------------------------------------------------------
module sfd_regs
    import sfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [31:0]           timeout_us
);

    logic [31:0] timeout_reg;
    logic [31:0] timeout_next;
    logic        sel_timeout;

    // Registers sit on 4-byte boundaries; the low address bits are ignored.
    assign sel_timeout = (paddr[APB_ADDR_W-1] == REG_TIMEOUT);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && sel_timeout)
        begin
            timeout_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = sel_timeout ? timeout_reg : 32'd0;
    assign timeout_us = timeout_reg;

endmodule

>>> design/sfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_dp
// Datapath: byte window, sync detection, channel unpacking and statistics.
// ----------------------------------------------------------------------------
module sfd_dp
    import sfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfd_cmd_t          cmd,
    output sfd_status_t       status,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       time_us,
    input  logic [31:0]       timeout_us,
    output logic              frame_decoded,
    output logic [IDX_W-1:0]  channel_index,
    output logic [CH_W-1:0]   channel_value,
    output logic              frame_lost,
    output logic              failsafe,
    output logic [31:0]       frames_total,
    output logic [31:0]       lost_total,
    output logic [31:0]       failsafe_total,
    output logic              data_valid,
    output logic              last
);

    // The previous WIN_LEN-1 bytes; entry 0 is the most recent.
    logic [7:0]        win_reg [WIN_LEN-1];
    logic [7:0]        win_next [WIN_LEN-1];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic [31:0]       frames_reg, frames_next;
    logic [31:0]       lost_cnt_reg, lost_cnt_next;
    logic [31:0]       fs_cnt_reg, fs_cnt_next;
    logic              lost_reg, lost_next;
    logic              fs_reg, fs_next;
    logic              valid_reg, valid_next;
    logic              is_frame_reg, is_frame_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] chan_sh_reg, chan_sh_next;
    logic              hit;
    logic              in_time;
    logic [31:0]       elapsed;
    logic [7:0]        flag_byte;

    // The current byte closes a frame whose start byte is the oldest entry.
    assign hit = (fill_reg >= FILL_W'(WIN_LEN - 1)) && (rx_byte == SYNC_TAIL)
               && (win_reg[WIN_LEN-2] == SYNC_HEAD);
    assign flag_byte = win_reg[0];
    assign elapsed   = time_us - last_time_reg;
    // On a new frame the elapsed time is zero.
    assign in_time   = hit ? (timeout_us != 32'd0) : (elapsed < timeout_us);

    always_comb
    begin
        for (int k = 0; k < WIN_LEN - 1; k++)
        begin
            win_next[k] = win_reg[k];
        end
        fill_next      = fill_reg;
        last_time_next = last_time_reg;
        frames_next    = frames_reg;
        lost_cnt_next  = lost_cnt_reg;
        fs_cnt_next    = fs_cnt_reg;
        lost_next      = lost_reg;
        fs_next        = fs_reg;
        valid_next     = valid_reg;
        is_frame_next  = is_frame_reg;
        idx_next       = idx_reg;
        chan_sh_next   = chan_sh_reg;

        if (cmd.load)
        begin
            win_next[0] = rx_byte;
            for (int k = 1; k < WIN_LEN - 1; k++)
            begin
                win_next[k] = win_reg[k-1];
            end
            if (fill_reg < FILL_W'(WIN_LEN))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            is_frame_next = hit;
            idx_next      = '0;
            if (hit)
            begin
                fill_next      = '0;
                last_time_next = time_us;
                frames_next    = frames_reg + 32'd1;
                lost_next      = flag_byte[FLAG_LOST_BIT];
                fs_next        = flag_byte[FLAG_FS_BIT];
                lost_cnt_next  = lost_cnt_reg + {31'd0, flag_byte[FLAG_LOST_BIT]};
                fs_cnt_next    = fs_cnt_reg + {31'd0, flag_byte[FLAG_FS_BIT]};
                // Data byte j of the frame sits at entry WIN_LEN-3-j.
                for (int j = 0; j < DATA_BYTES; j++)
                begin
                    chan_sh_next[8*j +: 8] = win_reg[WIN_LEN-3-j];
                end
            end
            valid_next = !fs_next && in_time && (frames_next != 32'd0);
        end
        else if (cmd.advance)
        begin
            idx_next     = idx_reg + IDX_W'(1);
            chan_sh_next = chan_sh_reg >> CH_W;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WIN_LEN - 1; k++)
        begin
            win_reg[k] <= win_next[k];
        end
        chan_sh_reg <= chan_sh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            last_time_reg <= '0;
            frames_reg    <= '0;
            lost_cnt_reg  <= '0;
            fs_cnt_reg    <= '0;
            lost_reg      <= 1'b0;
            fs_reg        <= 1'b0;
            valid_reg     <= 1'b0;
            is_frame_reg  <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            last_time_reg <= last_time_next;
            frames_reg    <= frames_next;
            lost_cnt_reg  <= lost_cnt_next;
            fs_cnt_reg    <= fs_cnt_next;
            lost_reg      <= lost_next;
            fs_reg        <= fs_next;
            valid_reg     <= valid_next;
            is_frame_reg  <= is_frame_next;
            idx_reg       <= idx_next;
        end
    end

    assign status.frame_hit = hit;
    assign status.chan_last = (idx_reg == IDX_W'(NUM_CH - 1));

    assign frame_decoded  = is_frame_reg;
    assign channel_index  = idx_reg;
    assign channel_value  = is_frame_reg ? chan_sh_reg[CH_W-1:0] : '0;
    assign frame_lost     = lost_reg;
    assign failsafe       = fs_reg;
    assign frames_total   = frames_reg;
    assign lost_total     = lost_cnt_reg;
    assign failsafe_total = fs_cnt_reg;
    assign data_valid     = valid_reg;
    assign last           = !is_frame_reg || status.chan_last;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_LEN))
        else $error("fill count beyond the window length");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && hit) |=> (is_frame_reg && idx_reg == '0 && fill_reg == '0))
        else $error("frame did not start at channel zero");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && hit) |=> (frames_reg == $past(frames_reg) + 32'd1))
        else $error("frame count not advanced on an accepted frame");
`endif

endmodule

>>> design/sfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl
// Controller: takes one byte, then drains its one or sixteen result beats.
// ----------------------------------------------------------------------------
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  sfd_status_t status,
    output sfd_cmd_t    cmd
);

    sfd_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.frame_hit ? ST_FRAME : ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRAME:
            begin
                if (!out_stall && status.chan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SINGLE:
            begin
                out_valid = 1'b1;
            end
            ST_FRAME:
            begin
                out_valid   = 1'b1;
                cmd.advance = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != ST_IDLE))
        else $error("accepted byte produced no result");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAME && !out_stall && status.chan_last) |=> (state_reg == ST_IDLE))
        else $error("frame drain overran the last channel");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_stall && !cmd.load))
        else $error("byte taken while results are pending");
`endif

endmodule

>>> design/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS byte stream decoder giving sixteen 11-bit channels, flags and counts.
// ----------------------------------------------------------------------------
// Each received byte, with its microsecond timestamp, is taken as one input
// beat. A byte that does not close a frame yields a single result beat with
// no channel data; a byte that closes a frame (0x00 end byte, 0x0F start byte
// twenty-four bytes earlier, and at least twenty-five bytes since the last
// frame) yields sixteen beats, channels 0 to 15 in order, with last on the
// sixteenth. A byte therefore occupies the block until its last beat has
// been taken, also while the output is stalled, and the block takes no new
// byte before then. The datapath's channel unpacker shifts out one
// channel per beat. Every beat carries the latest flags, the wrapping frame
// and flag counters, and data_valid, which needs a frame seen, the failsafe
// flag clear and less than timeout_us microseconds since the last frame.
// The timeout is register 0 on the APB port, reset to 200000.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
    import sfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Byte input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           time_us,
    // Result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  frame_decoded,
    output logic [IDX_W-1:0]      channel_index,
    output logic [CH_W-1:0]       channel_value,
    output logic                  frame_lost,
    output logic                  failsafe,
    output logic [31:0]           frames_total,
    output logic [31:0]           lost_total,
    output logic [31:0]           failsafe_total,
    output logic                  data_valid,
    output logic                  last
);

    logic [31:0] timeout_us;
    sfd_cmd_t    cmd;
    sfd_status_t status;

    // Users write timeout register only with no beat in flight; not enforced.
    sfd_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeout_us (timeout_us)
    );

    // The controller sequences one byte at a time through the datapath.
    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the byte window, the channel shifter and the
    // statistics; its registered fields are the output beat.
    sfd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .rx_byte        (rx_byte),
        .time_us        (time_us),
        .timeout_us     (timeout_us),
        .frame_decoded  (frame_decoded),
        .channel_index  (channel_index),
        .channel_value  (channel_value),
        .frame_lost     (frame_lost),
        .failsafe       (failsafe),
        .frames_total   (frames_total),
        .lost_total     (lost_total),
        .failsafe_total (failsafe_total),
        .data_valid     (data_valid),
        .last           (last)
    );

endmodule

>>> tb/tb_sbus_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// Self-checking bench for the SBUS frame decoder.
// ----------------------------------------------------------------------------
// SBUS bytes with timestamps are driven into the byte port, and every result
// beat is checked field by field against a bench-side model of the window,
// the frame counters and the timeout. A short table comes first: two bytes
// straight after reset with their results written out, then one complete
// frame with extreme channel data. After that comes a random stream. Most of
// it is well-formed frames with random content. The rest is noise and broken
// frames, so that the decoder has to resynchronise. The timeout register is
// changed between phases, and each phase uses its own idle pattern on the
// two sides.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder;
    import sfd_pkg::*;

    localparam int HALF_PERIOD_NS = 10;
    localparam int RUN_LIMIT_NS   = 6_000_000;
    localparam int DIRECTED_ROWS  = 27;
    localparam int RANDOM_BYTES   = 55;

    // Register 0 holds the timeout. Byte address 4 is not mapped, and a write
    // to it must leave the decoder unchanged.
    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT  = APB_ADDR_W'(4 * REG_TIMEOUT);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4);

    // One result beat, as the decoder should present it.
    typedef struct packed {
        logic             decoded;
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  value;
        logic             lost;
        logic             fs;
        logic [31:0]      frames;
        logic [31:0]      lost_n;
        logic [31:0]      fs_n;
        logic             valid;
        logic             last;
    } chan_beat_t;

    // One row of the directed table. Where 'typed' is set, the row's own
    // result (a single no-frame beat) replaces the predicted one.
    typedef struct packed {
        logic [7:0]  rx;
        logic [31:0] stamp;
        logic        typed;
        logic [31:0] want_frames;
        logic        want_valid;
    } byte_row_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte   = '0;
    logic [31:0]           time_us   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  frame_decoded;
    logic [IDX_W-1:0]      channel_index;
    logic [CH_W-1:0]       channel_value;
    logic                  frame_lost;
    logic                  failsafe;
    logic [31:0]           frames_total;
    logic [31:0]           lost_total;
    logic [31:0]           failsafe_total;
    logic                  data_valid;
    logic                  last;

    sbus_frame_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_decoded  (frame_decoded),
        .channel_index  (channel_index),
        .channel_value  (channel_value),
        .frame_lost     (frame_lost),
        .failsafe       (failsafe),
        .frames_total   (frames_total),
        .lost_total     (lost_total),
        .failsafe_total (failsafe_total),
        .data_valid     (data_valid),
        .last           (last)
    );

    // Bench copy of the decoder state. The ring is zeroed only for
    // tidiness: the fill guard means an unwritten entry is never read.
    logic [7:0]  ring [WIN_LEN] = '{default: 8'h00};
    int unsigned ring_wr     = 0;
    int unsigned ring_fill   = 0;
    logic [31:0] frame_stamp = '0;
    logic [31:0] frame_cnt   = '0;
    logic [31:0] lost_cnt    = '0;
    logic [31:0] fs_cnt      = '0;
    logic        lost_seen   = 1'b0;
    logic        fs_seen     = 1'b0;
    logic [31:0] timeout_reg = TIMEOUT_RESET;

    chan_beat_t  expected_beats [$];
    chan_beat_t  want;
    int          errors    = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic [31:0] stamp_us  = '0;

    // The directed table. The first two bytes arrive before any frame, so
    // nothing can be valid and every count is zero whatever the byte or the
    // time. A 0x00 byte this early must not close a frame, because fewer than
    // twenty-five bytes have arrived. Then one complete frame follows: all
    // data bytes 0xFF, so every channel reads 2047, and the lost flag is set.
    byte_row_t byte_table [DIRECTED_ROWS] = '{
        '{8'h00, 32'h0000_0000, 1'b1, 32'd0, 1'b0},
        '{8'hFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
        '{8'h0F, 32'd100, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd110, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd120, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd130, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd140, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd150, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd160, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd170, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd180, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd190, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd200, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd210, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd220, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd230, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd240, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd250, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd260, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd270, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd280, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd290, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd300, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd310, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 32'd320, 1'b0, 32'd0, 1'b0},
        '{8'h04, 32'd330, 1'b0, 32'd0, 1'b0},
        '{8'h00, 32'd340, 1'b0, 32'd0, 1'b0}
    };

    always
    begin
        #HALF_PERIOD_NS clk = 1'b1;
        #HALF_PERIOD_NS clk = 1'b0;
    end

    // Work out the result beats that one byte causes, and queue them.
    function automatic void decode_byte(input logic [7:0] rx, input logic [31:0] stamp);
        int unsigned       pos;
        int unsigned       head;
        int                k;
        logic [DATA_W-1:0] payload;
        logic [7:0]        flag_byte;
        logic [31:0]       elapsed;
        logic              hit;
        chan_beat_t        beat;
        pos  = ring_wr;
        head = (pos + 1) % WIN_LEN;
        ring[pos] = rx;
        if (ring_fill < WIN_LEN)
            ring_fill++;
        hit = (ring_fill >= WIN_LEN) && (rx == SYNC_TAIL) && (ring[head] == SYNC_HEAD);
        payload = '0;
        if (hit)
        begin
            // The slot after the write position holds the oldest byte, which
            // is the start byte of the frame. The data bytes follow it and
            // form one LSB-first bit stream.
            for (k = 0; k < DATA_BYTES; k++)
                payload[8*k +: 8] = ring[(head + 1 + k) % WIN_LEN];
            flag_byte   = ring[(head + DATA_BYTES + 1) % WIN_LEN];
            frame_stamp = stamp;
            frame_cnt   = frame_cnt + 1;
            ring_fill   = 0;
            lost_seen   = flag_byte[FLAG_LOST_BIT];
            fs_seen     = flag_byte[FLAG_FS_BIT];
            if (lost_seen)
                lost_cnt = lost_cnt + 1;
            if (fs_seen)
                fs_cnt = fs_cnt + 1;
        end
        ring_wr = head;
        elapsed = stamp - frame_stamp;
        beat.lost   = lost_seen;
        beat.fs     = fs_seen;
        beat.frames = frame_cnt;
        beat.lost_n = lost_cnt;
        beat.fs_n   = fs_cnt;
        beat.valid  = !fs_seen && (elapsed < timeout_reg) && (frame_cnt != 0);
        if (!hit)
        begin
            beat.decoded = 1'b0;
            beat.index   = '0;
            beat.value   = '0;
            beat.last    = 1'b1;
            expected_beats.push_back(beat);
        end
        else
        begin
            for (k = 0; k < NUM_CH; k++)
            begin
                beat.decoded = 1'b1;
                beat.index   = IDX_W'(k);
                beat.value   = payload[k*CH_W +: CH_W];
                beat.last    = (k == NUM_CH - 1);
                expected_beats.push_back(beat);
            end
        end
    endfunction

    function automatic logic [31:0] next_stamp();
        // Mostly short steps, so the timeout decides. Now and then there is a
        // jump anywhere in the 32-bit range, which also makes the time wrap.
        if ($urandom_range(0, 15) == 0)
            stamp_us = stamp_us + $urandom;
        else
            stamp_us = stamp_us + $urandom_range(1, 400);
        return stamp_us;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Present one byte, starting at a falling edge. The expected beats are
    // queued at once: the beat is never withdrawn, so it is certain to be
    // taken. The task returns at the falling edge that follows acceptance,
    // and leaves in_valid high so that a following byte can go straight out.
    task automatic send_byte(input logic [7:0] rx, input logic [31:0] stamp,
                             input logic typed, input logic [31:0] want_frames,
                             input logic want_valid);
        chan_beat_t row_beat;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= rx;
        time_us  <= stamp;
        decode_byte(rx, stamp);
        if (typed)
        begin
            row_beat = '0;
            row_beat.frames = want_frames;
            row_beat.valid  = want_valid;
            row_beat.last   = 1'b1;
            void'(expected_beats.pop_back());
            expected_beats.push_back(row_beat);
        end
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Hold off the sender until every queued beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_beats.size() != 0);
    endtask

    // One register write, then a read of the timeout to confirm what the
    // decoder now holds. Each is a setup phase followed by an access phase.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_TIMEOUT)
            timeout_reg = data;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TIMEOUT;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", timeout_reg, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The random stream of one phase. Most of it is whole frames; some are
    // cut short or given a wrong end byte, and some stretches are plain
    // noise. Halfway through, the sender waits until the decoder is empty.
    task automatic run_random(input int budget);
        logic [7:0] frame_bytes [WIN_LEN];
        int         sent;
        int         kind;
        int         style;
        int         len;
        int         k;
        bit         paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // Channel data is all zeros, all ones or random.
                style = $urandom_range(0, 3);
                frame_bytes[0] = SYNC_HEAD;
                for (k = 1; k <= DATA_BYTES; k++)
                    frame_bytes[k] = (style == 0) ? 8'h00 :
                                     (style == 1) ? 8'hFF : 8'($urandom);
                frame_bytes[WIN_LEN-2] = 8'($urandom);
                frame_bytes[WIN_LEN-1] = SYNC_TAIL;
                len = WIN_LEN;
                if (kind == 6)
                begin
                    if ($urandom_range(0, 1) == 1)
                        len = $urandom_range(1, WIN_LEN - 1);
                    else
                        frame_bytes[WIN_LEN-1] = 8'($urandom_range(1, 255));
                end
                for (k = 0; k < len; k++)
                    send_byte(frame_bytes[k], next_stamp(), 1'b0, '0, 1'b0);
                sent += len;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    send_byte(8'($urandom), next_stamp(), 1'b0, '0, 1'b0);
                sent += len;
            end
            if (!paused && sent >= budget / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    // The receiver stalls at random, whether or not a beat is on offer.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    // Every beat taken from the decoder is compared with the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, channel %0d value %0h",
                         $time, channel_index, channel_value);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("frame_decoded", 32'(want.decoded), 32'(frame_decoded));
                check_field("channel_index", 32'(want.index), 32'(channel_index));
                check_field("channel_value", 32'(want.value), 32'(channel_value));
                check_field("frame_lost", 32'(want.lost), 32'(frame_lost));
                check_field("failsafe", 32'(want.fs), 32'(failsafe));
                check_field("frames_total", want.frames, frames_total);
                check_field("lost_total", want.lost_n, lost_total);
                check_field("failsafe_total", want.fs_n, failsafe_total);
                check_field("data_valid", 32'(want.valid), 32'(data_valid));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int r;
        int phase;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The directed table runs with the reset timeout of 200000.
        send_idle = 29;
        recv_idle = 53;
        for (r = 0; r < DIRECTED_ROWS; r++)
            send_byte(byte_table[r].rx, byte_table[r].stamp, byte_table[r].typed,
                      byte_table[r].want_frames, byte_table[r].want_valid);
        drain();
        stamp_us = byte_table[DIRECTED_ROWS-1].stamp;

        // Phase 0 uses the shortest timeout, so only a frame's own end byte
        // can be valid. Phase 1 uses the longest, after a write to an unmapped
        // address that must be ignored. Phase 2 uses a random middle value.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 29;
                    recv_idle = 53;
                    write_reg(ADDR_TIMEOUT, 32'd1);
                end
                1:
                begin
                    send_idle = 53;
                    recv_idle = 29;
                    write_reg(ADDR_UNMAPPED, 32'h0000_0BAD);
                    write_reg(ADDR_TIMEOUT, 32'hFFFF_FFFF);
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_reg(ADDR_TIMEOUT, $urandom_range(2000, 20000));
                end
            endcase
            run_random(RANDOM_BYTES);
        end

        // Allow a little longer for any stray beat to show itself.
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/sfd_pkg.sv
design/sfd_regs.sv
design/sfd_dp.sv
design/sfd_ctrl.sv
design/sbus_frame_decoder.sv
tb/tb_sbus_frame_decoder.sv
